// ----- hw/rtl/fvcw_pkg.sv -----
// Package for the flow vector color wheel: wheel table, CORDIC arctangents,
// pipeline latencies and shared widths. No dependencies.
package fvcw_pkg;

  localparam int SEG_RY = 15;
  localparam int SEG_YG = 6;
  localparam int SEG_GC = 4;
  localparam int SEG_CB = 11;
  localparam int SEG_BM = 13;
  localparam int SEG_MR = 6;
  localparam int WHEEL_STEPS = 54;
  localparam int WHEEL_SIZE = WHEEL_STEPS + 1;
  localparam int CORDIC_STEPS = 14;
  localparam int CORDIC_W = 28;
  localparam int SQRT_STEPS = 17;
  localparam int RAD_LAT = 4 + SQRT_STEPS;
  localparam int ANG_LAT = 1 + CORDIC_STEPS;
  localparam int ANG_DELAY = RAD_LAT - ANG_LAT;
  localparam logic [16:0] INV_RESET = 17'd65536;

  typedef logic [7:0] chan_t;
  typedef logic [23:0] rgb_t;

  localparam logic [15:0] ATAN_TURNS [CORDIC_STEPS] = '{
    16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163,
    16'd81, 16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1
  };

  // Entry k as {red, green, blue}; evaluated only at elaboration.
  function automatic rgb_t wheel_entry(int k);
    int r;
    int g;
    int b;
    int j;
    j = k;
    r = 0;
    g = 0;
    b = 0;
    if (j < SEG_RY) begin
      r = 255; g = 255 * j / SEG_RY;
    end else begin
      j = j - SEG_RY;
      if (j < SEG_YG) begin
        r = 255 - 255 * j / SEG_YG; g = 255;
      end else begin
        j = j - SEG_YG;
        if (j < SEG_GC) begin
          g = 255; b = 255 * j / SEG_GC;
        end else begin
          j = j - SEG_GC;
          if (j < SEG_CB) begin
            g = 255 - 255 * j / SEG_CB; b = 255;
          end else begin
            j = j - SEG_CB;
            if (j < SEG_BM) begin
              r = 255 * j / SEG_BM; b = 255;
            end else begin
              j = j - SEG_BM;
              if (j >= SEG_MR) j = SEG_MR - 1;
              r = 255; b = 255 - 255 * j / SEG_MR;
            end
          end
        end
      end
    end
    return {8'(r), 8'(g), 8'(b)};
  endfunction

  typedef rgb_t wheel_tab_t [WHEEL_SIZE];

  function automatic wheel_tab_t build_wheel();
    wheel_tab_t w;
    for (int k = 0; k < WHEEL_SIZE; k++) begin
      w[k] = wheel_entry(k);
    end
    return w;
  endfunction

  localparam wheel_tab_t WHEEL = build_wheel();

endpackage

// ----- hw/rtl/fvcw_if.sv -----
// Valid/ready channel interfaces for flow vectors in and colors out.
// Depends on nothing.
interface fvcw_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] flow_x;
  logic signed [15:0] flow_y;
  logic              flow_valid;
  modport source (output valid, flow_x, flow_y, flow_valid, input ready);
  modport sink (input valid, flow_x, flow_y, flow_valid, output ready);
endinterface

interface fvcw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

// ----- hw/rtl/fvcw_radius.sv -----
// Normalized radius pipeline: scaling multiply, range test, squares and a
// one-bit-per-stage square root. Depends on fvcw_pkg.
module fvcw_radius import fvcw_pkg::*; #(
  parameter int unsigned FRAC_BITS = 5
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] flow_x,
  input  logic signed [15:0] flow_y,
  input  logic [16:0]        inv,
  output logic [16:0]        rad,
  output logic               in_unit
);
  localparam int NW = FRAC_BITS + 17;
  localparam int SQW = 2 * NW;
  localparam int SUMW = SQW + 1;
  localparam logic [32:0] LIM = 33'(1) << (FRAC_BITS + 16);
  localparam logic [SUMW-1:0] SUM_LIM = SUMW'(1) << (2 * FRAC_BITS + 32);

  logic signed [32:0] nx_r, ny_r;
  logic [32:0]        ax, ay;
  logic [NW-1:0]      ax_r, ay_r;
  logic               inr_r, inr2_r, ins_s_r;
  logic [SQW-1:0]     sqx_r, sqy_r;
  logic [SUMW-1:0]    sum, sum_sh;
  logic [32:0]        s_r;
  logic [33:0]        rem_r [SQRT_STEPS];
  logic [33:0]        root_r [SQRT_STEPS];
  logic               ins_r [SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r <= 33'(flow_x) * 33'($signed({1'b0, inv}));
      ny_r <= 33'(flow_y) * 33'($signed({1'b0, inv}));
    end
  end

  assign ax = nx_r[32] ? 33'(-nx_r) : 33'(nx_r);
  assign ay = ny_r[32] ? 33'(-ny_r) : 33'(ny_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r  <= ax[NW-1:0];
      ay_r  <= ay[NW-1:0];
      inr_r <= (ax <= LIM) && (ay <= LIM);
      sqx_r <= SQW'(ax_r) * SQW'(ax_r);
      sqy_r <= SQW'(ay_r) * SQW'(ay_r);
      inr2_r <= inr_r;
    end
  end

  assign sum = SUMW'(sqx_r) + SUMW'(sqy_r);
  assign sum_sh = sum >> (2 * FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      s_r     <= sum_sh[32:0];
      ins_s_r <= inr2_r && (sum <= SUM_LIM);
    end
  end

  // Digit recurrence square root, one result bit per stage.
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    localparam logic [33:0] BIT = 34'(1) << (32 - 2 * i);
    logic [33:0] cur_rem, cur_root, trial;
    logic        cur_ins;
    if (i == 0) begin : g_first
      assign cur_rem  = {1'b0, s_r};
      assign cur_root = '0;
      assign cur_ins  = ins_s_r;
    end else begin : g_next
      assign cur_rem  = rem_r[i-1];
      assign cur_root = root_r[i-1];
      assign cur_ins  = ins_r[i-1];
    end
    assign trial = cur_root + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        ins_r[i] <= cur_ins;
        if (cur_rem >= trial) begin
          rem_r[i]  <= cur_rem - trial;
          root_r[i] <= (cur_root >> 1) + BIT;
        end else begin
          rem_r[i]  <= cur_rem;
          root_r[i] <= cur_root >> 1;
        end
      end
    end
  end

  assign rad = root_r[SQRT_STEPS-1][16:0];
  assign in_unit = ins_r[SQRT_STEPS-1];
endmodule

// ----- hw/rtl/fvcw_angle.sv -----
// Pipelined CORDIC vectoring that gives the direction of the negated flow in 1/65536 turn.
// Depends on fvcw_pkg.
module fvcw_angle import fvcw_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] flow_x,
  input  logic signed [15:0] flow_y,
  output logic [15:0]        angle
);
  logic signed [CORDIC_W-1:0] xs, ys;
  logic signed [CORDIC_W-1:0] x_r [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] y_r [CORDIC_STEPS+1];
  logic [15:0]                z_r [CORDIC_STEPS+1];

  assign xs = {{(CORDIC_W - 24){flow_x[15]}}, flow_x, 8'b0};
  assign ys = {{(CORDIC_W - 24){flow_y[15]}}, flow_y, 8'b0};

  // The vector is the negated flow; rotate into the right half plane first.
  always_ff @(posedge clk) begin
    if (en) begin
      if (flow_x > 16'sd0) begin
        x_r[0] <= xs;
        y_r[0] <= ys;
        z_r[0] <= 16'h8000;
      end else begin
        x_r[0] <= -xs;
        y_r[0] <= -ys;
        z_r[0] <= 16'h0000;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CORDIC_W-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + ATAN_TURNS[i];
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - ATAN_TURNS[i];
        end
      end
    end
  end

  assign angle = z_r[CORDIC_STEPS];
endmodule

// ----- hw/rtl/fvcw_color.sv -----
// Color stages: wheel position, interpolation, saturation blend and output
// register. Depends on fvcw_pkg.
module fvcw_color import fvcw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld,
  input  logic        flow_valid,
  input  logic [15:0] angle,
  input  logic [16:0] rad,
  input  logic        in_unit,
  output logic        out_vld,
  output chan_t       red,
  output chan_t       green,
  output chan_t       blue
);
  localparam logic [39:0] FULL = 40'hFF_0000_0000;

  logic [15:0] t;
  logic [21:0] p;
  logic [5:0]  k0_r, k1;
  logic [15:0] f_r;
  logic [16:0] rad1_r, rad2_r;
  logic [3:0]  vld_r;
  logic [2:0]  fv_r, ins_r;
  rgb_t        w0, w1;
  logic [16:0] fc;
  logic [23:0] c_r [3];
  logic [23:0] c3_r [3];
  logic [40:0] prod_r [3];
  chan_t       ch_r [3];

  assign t = angle ^ 16'h8000;
  assign p = 22'(t) * 22'(WHEEL_STEPS);
  assign k1 = k0_r + 6'd1;
  assign w0 = WHEEL[k0_r];
  assign w1 = WHEEL[k1];
  assign fc = 17'd65536 - 17'(f_r);

  // Four register stages, so the valid bit travels with the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fv_r   <= {fv_r[1:0], flow_valid};
      ins_r  <= {ins_r[1:0], in_unit};
      k0_r   <= p[21:16];
      f_r    <= p[15:0];
      rad1_r <= rad;
      rad2_r <= rad1_r;
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    logic [7:0]  e0, e1;
    logic [23:0] d;
    logic [39:0] blend;
    logic [25:0] dim;
    assign e0 = w0[23 - 8 * ch -: 8];
    assign e1 = w1[23 - 8 * ch -: 8];
    assign d = 24'hFF0000 - c_r[ch];
    assign blend = FULL - prod_r[ch][39:0];
    assign dim = 26'(c3_r[ch]) * 26'd3;
    always_ff @(posedge clk) begin
      if (en) begin
        c_r[ch]    <= 24'(25'(e0) * 25'(fc) + 25'(e1) * 25'(f_r));
        prod_r[ch] <= 41'(d) * 41'(rad2_r);
        c3_r[ch]   <= c_r[ch];
        if (!fv_r[2]) begin
          ch_r[ch] <= '0;
        end else if (ins_r[2]) begin
          ch_r[ch] <= blend[39:32];
        end else begin
          ch_r[ch] <= dim[25:18];
        end
      end
    end
  end

  assign out_vld = vld_r[3];
  assign red = ch_r[0];
  assign green = ch_r[1];
  assign blue = ch_r[2];
endmodule

// ----- hw/rtl/flow_vector_color_wheel_core.sv -----
// Top level of the flow vector color wheel. Depends on fvcw_pkg, the channel
// interfaces, fvcw_radius, fvcw_angle and fvcw_color.
//
// One flow vector (signed fixed point) enters on in_if per transaction and one
// RGB color leaves on out_if per transaction, in order. cfg_wr_en writes the
// reciprocal of the maximum radius (unsigned Q1.16) from cfg_wr_data; write it
// only while no transaction is in flight.
// Depth is set by the square root stages (one root bit per stage) behind the
// scaling multiply and the squares; the CORDIC angle runs alongside and is
// delayed to match. Throughput is one transaction per cycle while the
// receiver takes the output. The whole pipeline advances while the output
// register is empty or taken; when the receiver stalls, every stage holds
// and in_if.ready drops in the same cycle, so nothing is lost. Synchronous
// reset clears all valid bits and loads the register with one (65536); no
// clearing pass is needed since the unreset data registers only move with those valid bits.
module flow_vector_color_wheel_core import fvcw_pkg::*; #(
  parameter int unsigned FLOW_FRACTION_BITS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  fvcw_in_if.sink     in_if,
  fvcw_out_if.source  out_if
);
  logic        en;
  logic [16:0] inv_r;
  logic        vld_r [RAD_LAT];
  logic        fv_r [RAD_LAT];
  logic [15:0] ang;
  logic [15:0] ang_d_r [ANG_DELAY];
  logic [16:0] rad;
  logic        in_unit;

  assign en = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= INV_RESET;
    end else if (cfg_wr_en) begin
      inv_r <= cfg_wr_data;
    end
  end

  for (genvar i = 0; i < RAD_LAT; i++) begin : g_vld
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= (i == 0) ? in_if.valid : vld_r[(i == 0) ? 0 : i - 1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        fv_r[i] <= (i == 0) ? in_if.flow_valid : fv_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  fvcw_radius #(.FRAC_BITS(FLOW_FRACTION_BITS)) u_radius (
    .clk     (clk),
    .en      (en),
    .flow_x  (in_if.flow_x),
    .flow_y  (in_if.flow_y),
    .inv     (inv_r),
    .rad     (rad),
    .in_unit (in_unit)
  );

  fvcw_angle u_angle (
    .clk    (clk),
    .en     (en),
    .flow_x (in_if.flow_x),
    .flow_y (in_if.flow_y),
    .angle  (ang)
  );

  for (genvar i = 0; i < ANG_DELAY; i++) begin : g_ang
    always_ff @(posedge clk) begin
      if (en) begin
        ang_d_r[i] <= (i == 0) ? ang : ang_d_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  fvcw_color u_color (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .vld        (vld_r[RAD_LAT-1]),
    .flow_valid (fv_r[RAD_LAT-1]),
    .angle      (ang_d_r[ANG_DELAY-1]),
    .rad        (rad),
    .in_unit    (in_unit),
    .out_vld    (out_if.valid),
    .red        (out_if.red),
    .green      (out_if.green),
    .blue       (out_if.blue)
  );

  a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.ready == (!out_if.valid || out_if.ready))
    else $error("input ready does not follow output stall");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> inv_r == $past(cfg_wr_data))
    else $error("configuration write lost");

  a_rad_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[RAD_LAT-1] && in_unit) |-> rad <= 17'd65536)
    else $error("normalized radius above one inside the unit circle");

  a_stall_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[RAD_LAT-1] && !en) |=> vld_r[RAD_LAT-1])
    else $error("pipeline transaction dropped during stall");
endmodule
